FILE: rtl/rbst_pkg.sv
`timescale 1ns / 1ps
package rbst_pkg;
	localparam int CW = 32;
	localparam int FRAC = 16;
	// magnitude of (bound - origin) with fraction bits appended
	localparam int NW = CW + 1 + FRAC;
	// dividend bits above the quotient window
	localparam int HW = NW - CW;
	// divider latency: input stage, one stage per quotient bit, output stage
	localparam int DIV_LAT = CW + 2;
	// full pipeline: divider, per-axis min/max, final compare
	localparam int DEPTH = DIV_LAT + 2;
	localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] T_ZERO = '0;

	function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		return (a < b) ? a : b;
	endfunction
endpackage

FILE: rtl/rbst_slab_div.sv
`timescale 1ns / 1ps
module rbst_slab_div import rbst_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] bound,
	input  logic signed [CW-1:0] origin,
	input  logic signed [CW-1:0] dir,
	output logic signed [CW-1:0] t
);
	logic [CW:0]   diff;
	logic          nneg;
	logic [CW:0]   nmag;
	logic [NW-1:0] num;
	logic          dneg;
	logic [CW-1:0] dmag;
	logic          ovf;

	logic [CW-1:0] rem_sk [0:CW];
	logic [CW-1:0] dvd_sk [0:CW];
	logic [CW-1:0] quo_sk [0:CW];
	logic [CW-1:0] dmag_sk [0:CW];
	logic          neg_sk [0:CW];
	logic          ovf_sk [0:CW];

	// form the exact numerator magnitude and divisor magnitude
	always_comb begin
		diff = {bound[CW-1], bound} - {origin[CW-1], origin};
		nneg = diff[CW];
		nmag = nneg ? (~diff + 1'b1) : diff;
		num = {nmag, {FRAC{1'b0}}};
		dneg = dir[CW-1];
		dmag = dneg ? (~dir + 1'b1) : dir;
		ovf = ({{(CW-HW){1'b0}}, num[NW-1:CW]} >= dmag);
	end

	// load the first stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sk[0] <= {{(CW-HW){1'b0}}, num[NW-1:CW]};
			dvd_sk[0] <= num[CW-1:0];
			quo_sk[0] <= '0;
			dmag_sk[0] <= dmag;
			neg_sk[0] <= nneg ^ dneg;
			ovf_sk[0] <= ovf;
		end
	end

	// one restoring step per stage, one quotient bit each
	for (genvar k = 1; k <= CW; k++) begin : g_step
		logic [CW:0] r;
		logic        ge;
		logic [CW:0] rd;
		always_comb begin
			r = {rem_sk[k-1], dvd_sk[k-1][CW-1]};
			ge = (r >= {1'b0, dmag_sk[k-1]});
			rd = r - {1'b0, dmag_sk[k-1]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k] <= ge ? rd[CW-1:0] : r[CW-1:0];
				dvd_sk[k] <= {dvd_sk[k-1][CW-2:0], 1'b0};
				quo_sk[k] <= {quo_sk[k-1][CW-2:0], ge};
				dmag_sk[k] <= dmag_sk[k-1];
				neg_sk[k] <= neg_sk[k-1];
				ovf_sk[k] <= ovf_sk[k-1];
			end
		end
	end

	// saturate and apply the sign
	logic [CW-1:0] lim;
	logic [CW-1:0] mag;
	always_comb begin
		lim = neg_sk[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		mag = (ovf_sk[CW] || quo_sk[CW] > lim) ? lim : quo_sk[CW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t <= neg_sk[CW] ? (~mag + 1'b1) : mag;
		end
	end
endmodule

FILE: rtl/ray_box_slab_test_core.sv
`timescale 1ns / 1ps
// Ray versus axis-aligned box slab test, signed Q16.16 coordinates.
// Input channel: in_valid/in_ready with the ray origin, direction and the box
// corners; a request is taken when both are high. Output channel:
// out_valid/out_ready with hit, one result per request, in order.
// From acceptance to out_valid a request passes, in order, a register that
// holds the slab numerators, a pipelined restoring divider (one quotient
// bit per stage, six lanes in parallel), a saturation register, a per-axis
// min/max register and a final interval compare register. Throughput is one
// request per cycle while the output is not stalled.
// The whole pipeline advances on one enable: in_ready is high while the
// output register is empty or being taken. When the receiver holds
// out_ready low with a result waiting, every stage holds and no request is
// lost or repeated. Reset (arst_n low) clears all valid bits; the data
// path has no reset and there is no other state.
module ray_box_slab_test_core import rbst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] origin_x,
	input  logic signed [CW-1:0] origin_y,
	input  logic signed [CW-1:0] origin_z,
	input  logic signed [CW-1:0] dir_x,
	input  logic signed [CW-1:0] dir_y,
	input  logic signed [CW-1:0] dir_z,
	input  logic signed [CW-1:0] box_min_x,
	input  logic signed [CW-1:0] box_min_y,
	input  logic signed [CW-1:0] box_min_z,
	input  logic signed [CW-1:0] box_max_x,
	input  logic signed [CW-1:0] box_max_y,
	input  logic signed [CW-1:0] box_max_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit
);
	logic                 en;
	logic [DEPTH-1:0]     vld_q;
	logic signed [CW-1:0] org [0:2];
	logic signed [CW-1:0] dir [0:2];
	logic signed [CW-1:0] bmin [0:2];
	logic signed [CW-1:0] bmax [0:2];
	logic signed [CW-1:0] t1 [0:2];
	logic signed [CW-1:0] t2 [0:2];
	logic [2:0]           skip_in;
	logic                 pass_in;
	logic [2:0]           skip_sk [0:DIV_LAT-1];
	logic                 pass_sk [0:DIV_LAT-1];
	logic signed [CW-1:0] lo_s1 [0:2];
	logic signed [CW-1:0] hi_s1 [0:2];
	logic                 pass_s1;

	assign en = !vld_q[DEPTH-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[DEPTH-1];

	assign org = '{origin_x, origin_y, origin_z};
	assign dir = '{dir_x, dir_y, dir_z};
	assign bmin = '{box_min_x, box_min_y, box_min_z};
	assign bmax = '{box_max_x, box_max_y, box_max_z};

	// parallel axes: origin must lie strictly inside the slab
	always_comb begin
		pass_in = 1'b1;
		for (int a = 0; a < 3; a++) begin
			skip_in[a] = (dir[a] == T_ZERO);
			if (skip_in[a] && !(bmin[a] < org[a] && org[a] < bmax[a])) begin
				pass_in = 1'b0;
			end
		end
	end

	// six divider lanes, two per axis
	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbst_slab_div u_div_min (
			.clk(clk), .en(en), .bound(bmin[a]), .origin(org[a]), .dir(dir[a]), .t(t1[a])
		);
		rbst_slab_div u_div_max (
			.clk(clk), .en(en), .bound(bmax[a]), .origin(org[a]), .dir(dir[a]), .t(t2[a])
		);
	end

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// carry the parallel-axis flags alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			skip_sk[0] <= skip_in;
			pass_sk[0] <= pass_in;
			for (int k = 1; k < DIV_LAT; k++) begin
				skip_sk[k] <= skip_sk[k-1];
				pass_sk[k] <= pass_sk[k-1];
			end
		end
	end

	// order each axis pair, drop parallel axes to the neutral interval
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				lo_s1[a] <= skip_sk[DIV_LAT-1][a] ? T_ZERO : smin(t1[a], t2[a]);
				hi_s1[a] <= skip_sk[DIV_LAT-1][a] ? T_MAX : smax(t1[a], t2[a]);
			end
			pass_s1 <= pass_sk[DIV_LAT-1];
		end
	end

	// narrow the interval and register the result
	logic signed [CW-1:0] near_v;
	logic signed [CW-1:0] far_v;
	always_comb begin
		near_v = smax(smax(T_ZERO, lo_s1[0]), smax(lo_s1[1], lo_s1[2]));
		far_v = smin(smin(T_MAX, hi_s1[0]), smin(hi_s1[1], hi_s1[2]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= pass_s1 && (near_v < far_v);
		end
	end

	// hold the whole pipeline while a result waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(vld_q) && $stable(hit)))
		else $error("pipeline moved while output stalled");
	// a request enters exactly when the front valid bit is loaded
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted request not tracked");
	// a taken result frees the output or refills it from the stage behind
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !vld_q[DEPTH-2]) |=> !out_valid)
		else $error("result repeated");
endmodule
